// ===== design/fva_pkg.sv =====
// ----------------------------------------------------------------------------
// fva_pkg
// Shared constants, types and codes of the flagged visibility averager.
// ----------------------------------------------------------------------------
package fva_pkg;

    localparam int NUM_CHANNELS  = 1024;
    localparam int COUNT_BITS    = 16;
    localparam int SAMPLE_BITS   = 24;
    localparam int NUM_BASELINES = 3;
    localparam int NUM_POLS      = 2;
    localparam int SKIP_BITS     = 16;
    localparam int SKIP_RESET    = 135;

    localparam int SUM_W    = SAMPLE_BITS + COUNT_BITS;
    localparam int ENTRIES  = NUM_BASELINES * NUM_CHANNELS * NUM_POLS;
    localparam int ENTRY_AW = $clog2(ENTRIES);

    typedef logic [ENTRY_AW-1:0]          t_addr;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic [COUNT_BITS-1:0]        t_cnt;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // One accumulator entry as it is held in the memory.
    typedef struct packed {
        t_sum sum_re;
        t_sum sum_im;
        t_cnt cnt;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        STS_ADDED        = 3'd0,
        STS_SETTLING     = 3'd1,
        STS_BAD_BASELINE = 3'd2,
        STS_UNUSED_POL   = 3'd3,
        STS_FLAGGED      = 3'd4,
        STS_COUNT_FULL   = 3'd5,
        STS_READ_OK      = 3'd6,
        STS_READ_EMPTY   = 3'd7
    } t_status;

    typedef enum logic {
        OP_ACCUMULATE = 1'b0,
        OP_READ       = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        FS_CLEAR,
        FS_IDLE,
        FS_LOOK,
        FS_EXEC,
        FS_DIV
    } t_state;

endpackage

// ===== design/fva_ram.sv =====
// ----------------------------------------------------------------------------
// fva_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/fva_div.sv =====
// ----------------------------------------------------------------------------
// fva_div
// Two-lane restoring divider: signed sums over an unsigned, non-zero count,
// one quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module fva_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fva_pkg::t_sum     i_num_re,
    input  fva_pkg::t_sum     i_num_im,
    input  fva_pkg::t_cnt     i_den,
    output logic              o_done,
    output fva_pkg::t_sample  o_quo_re,
    output fva_pkg::t_sample  o_quo_im
);

    localparam int CW = $clog2(fva_pkg::SUM_W + 1);

    logic                          r_run;
    logic                          r_done;
    logic [CW-1:0]                 r_steps;
    logic [fva_pkg::SUM_W-1:0]     r_q   [2];
    logic [fva_pkg::COUNT_BITS-1:0] r_rem [2];
    logic                          r_neg [2];
    fva_pkg::t_cnt                 r_den;

    logic [fva_pkg::SUM_W-1:0]     n_q   [2];
    logic [fva_pkg::COUNT_BITS-1:0] n_rem [2];
    logic [fva_pkg::SUM_W-1:0]     q_signed [2];

    // One restoring step for each lane: the dividend shifts out at the top
    // while quotient bits shift in at the bottom of the same register.
    always_comb begin
        logic [fva_pkg::COUNT_BITS:0] rem_sh;
        for (int l = 0; l < 2; l++) begin
            rem_sh = {r_rem[l], r_q[l][fva_pkg::SUM_W-1]};
            if (rem_sh >= {1'b0, r_den}) begin
                rem_sh   = rem_sh - {1'b0, r_den};
                n_q[l]   = {r_q[l][fva_pkg::SUM_W-2:0], 1'b1};
            end else begin
                n_q[l]   = {r_q[l][fva_pkg::SUM_W-2:0], 1'b0};
            end
            n_rem[l] = rem_sh[fva_pkg::COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_steps == CW'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_steps  <= CW'(fva_pkg::SUM_W);
            r_den    <= i_den;
            r_neg[0] <= i_num_re[fva_pkg::SUM_W-1];
            r_neg[1] <= i_num_im[fva_pkg::SUM_W-1];
            r_q[0]   <= i_num_re[fva_pkg::SUM_W-1] ? -i_num_re : i_num_re;
            r_q[1]   <= i_num_im[fva_pkg::SUM_W-1] ? -i_num_im : i_num_im;
            r_rem[0] <= '0;
            r_rem[1] <= '0;
        end else if (r_run) begin
            r_steps <= r_steps - CW'(1);
            r_q     <= n_q;
            r_rem   <= n_rem;
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            q_signed[l] = r_neg[l] ? -r_q[l] : r_q[l];
        end
    end

    assign o_done   = r_done;
    assign o_quo_re = q_signed[0][fva_pkg::SAMPLE_BITS-1:0];
    assign o_quo_im = q_signed[1][fva_pkg::SAMPLE_BITS-1:0];

endmodule

// ===== design/flagged_visibility_averager.sv =====
// ----------------------------------------------------------------------------
// flagged_visibility_averager
// Per-baseline, per-channel, per-polarisation accumulate-and-dump averager.
// ----------------------------------------------------------------------------
// After reset the block sweeps its accumulator memory clear, one entry a
// cycle, and holds busy high for the whole sweep. It then takes one item at
// a time: an accumulate beat, or a read that finds nothing to divide, goes
// from start through the memory read, then the read-modify-write with the
// result registered, to the result strobe, and a read-and-clear beat of a
// non-empty entry further waits on the divider, which produces one quotient
// bit per cycle over the 40-bit sums. Busy falls in the cycle the result
// strobe is shown, so the next beat may start then. The result is on the
// output ports for exactly that one cycle and must be taken there; the skip
// register may be written at any time the block is idle.
module flagged_visibility_averager (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_cfg_we,
    input  logic [15:0]              i_cfg_wdata,
    input  logic                     i_opcode,
    input  logic [31:0]              i_timestamp,
    input  logic [7:0]               i_antenna_a,
    input  logic [7:0]               i_antenna_b,
    input  logic [1:0]               i_pol_product,
    input  logic [9:0]               i_channel,
    input  logic                     i_flagged,
    input  logic signed [23:0]       i_vis_re,
    input  logic signed [23:0]       i_vis_im,
    input  logic [1:0]               i_read_baseline,
    input  logic                     i_read_pol,
    output logic                     o_strobe,
    output logic [2:0]               o_status,
    output logic signed [23:0]       o_avg_re,
    output logic signed [23:0]       o_avg_im,
    output logic [15:0]              o_sample_count
);

    fva_pkg::t_state   r_state, n_state;
    logic [15:0]       r_skip;
    logic              r_first_seen;
    logic [31:0]       r_first_time;
    fva_pkg::t_addr    r_clr_addr;

    // Captured beat
    logic              r_opcode;
    logic [31:0]       r_ts;
    logic [7:0]        r_ant_a;
    logic [7:0]        r_ant_b;
    logic [1:0]        r_polp;
    logic [9:0]        r_channel;
    logic              r_flagged;
    fva_pkg::t_sample  r_vis_re;
    fva_pkg::t_sample  r_vis_im;
    logic [1:0]        r_rbl;
    logic              r_rpol;

    // Decisions taken before the memory answers
    logic              r_pre_ok;
    fva_pkg::t_status  r_pre_status;
    fva_pkg::t_addr    r_addr;
    fva_pkg::t_cnt     r_cnt_hold;

    logic              r_strobe;
    fva_pkg::t_status  r_status;
    fva_pkg::t_sample  r_avg_re;
    fva_pkg::t_sample  r_avg_im;
    fva_pkg::t_cnt     r_count;

    logic              n_strobe;
    fva_pkg::t_status  n_status;
    fva_pkg::t_sample  n_avg_re;
    fva_pkg::t_sample  n_avg_im;
    fva_pkg::t_cnt     n_count;

    logic              pre_ok;
    fva_pkg::t_status  pre_status;
    fva_pkg::t_addr    look_addr;
    logic              first_now;

    logic              ram_we;
    logic              ram_re;
    fva_pkg::t_addr    ram_waddr;
    fva_pkg::t_entry   ram_wdata;
    fva_pkg::t_entry   ram_rdata;

    logic              cnt_full;
    logic              div_start;
    logic              div_done;
    fva_pkg::t_sample  div_re;
    fva_pkg::t_sample  div_im;

    logic              accept;

    assign accept = start && !busy;

    // ---------------------------------------------------------------- checks
    always_comb begin
        logic [31:0] eff_first;
        logic [31:0] diff;
        logic        settle;
        logic [1:0]  bl;
        logic        bl_ok;
        logic        pol;
        logic        ch_ok;
        logic [1:0]  sel_bl;
        logic        sel_pol;

        first_now = (r_opcode == fva_pkg::OP_ACCUMULATE) && !r_first_seen;
        eff_first = r_first_seen ? r_first_time : r_ts;
        diff      = r_ts - eff_first;
        settle    = (r_ts < eff_first) || (diff < {16'b0, r_skip});

        bl_ok = 1'b1;
        if (r_ant_a == 8'd0 && r_ant_b == 8'd1) begin
            bl = 2'd0;
        end else if (r_ant_a == 8'd0 && r_ant_b == 8'd2) begin
            bl = 2'd1;
        end else if (r_ant_a == 8'd1 && r_ant_b == 8'd2) begin
            bl = 2'd2;
        end else begin
            bl    = 2'd0;
            bl_ok = 1'b0;
        end
        pol   = (r_polp != 2'd0);
        ch_ok = 32'(r_channel) < 32'(fva_pkg::NUM_CHANNELS);

        pre_ok     = 1'b0;
        pre_status = fva_pkg::STS_READ_EMPTY;
        if (r_opcode == fva_pkg::OP_ACCUMULATE) begin
            sel_bl  = bl;
            sel_pol = pol;
            if (settle) begin
                pre_status = fva_pkg::STS_SETTLING;
            end else if (!bl_ok) begin
                pre_status = fva_pkg::STS_BAD_BASELINE;
            end else if (r_polp inside {2'd1, 2'd2}) begin
                pre_status = fva_pkg::STS_UNUSED_POL;
            end else if (r_flagged) begin
                pre_status = fva_pkg::STS_FLAGGED;
            end else if (!ch_ok) begin
                pre_status = fva_pkg::STS_BAD_BASELINE;
            end else begin
                pre_status = fva_pkg::STS_ADDED;
                pre_ok     = 1'b1;
            end
        end else begin
            sel_bl  = r_rbl;
            sel_pol = r_rpol;
            pre_ok  = (32'(r_rbl) < 32'(fva_pkg::NUM_BASELINES)) && ch_ok;
        end

        look_addr = fva_pkg::t_addr'((32'(sel_bl) * 32'(fva_pkg::NUM_CHANNELS)
                    + 32'(r_channel)) * 32'(fva_pkg::NUM_POLS) + 32'(sel_pol));
    end

    assign cnt_full = (ram_rdata.cnt == '1);

    // ---------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fva_pkg::FS_CLEAR: begin
                if (r_clr_addr == fva_pkg::t_addr'(fva_pkg::ENTRIES - 1)) begin
                    n_state = fva_pkg::FS_IDLE;
                end
            end
            fva_pkg::FS_IDLE: begin
                if (start) begin
                    n_state = fva_pkg::FS_LOOK;
                end
            end
            fva_pkg::FS_LOOK: begin
                n_state = fva_pkg::FS_EXEC;
            end
            fva_pkg::FS_EXEC: begin
                if (div_start) begin
                    n_state = fva_pkg::FS_DIV;
                end else begin
                    n_state = fva_pkg::FS_IDLE;
                end
            end
            fva_pkg::FS_DIV: begin
                if (div_done) begin
                    n_state = fva_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = fva_pkg::FS_IDLE;
            end
        endcase
    end

    // --------------------------------------------------------------- outputs
    always_comb begin
        busy      = (r_state != fva_pkg::FS_IDLE);
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        div_start = 1'b0;
        n_strobe  = 1'b0;
        n_status  = r_pre_status;
        n_avg_re  = '0;
        n_avg_im  = '0;
        n_count   = '0;
        case (r_state)
            fva_pkg::FS_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
            end
            fva_pkg::FS_LOOK: begin
                ram_re = 1'b1;
            end
            fva_pkg::FS_EXEC: begin
                if (!r_pre_ok) begin
                    n_strobe = 1'b1;
                end else if (r_opcode == fva_pkg::OP_ACCUMULATE) begin
                    n_strobe = 1'b1;
                    if (cnt_full) begin
                        n_status = fva_pkg::STS_COUNT_FULL;
                    end else begin
                        n_status         = fva_pkg::STS_ADDED;
                        ram_we           = 1'b1;
                        ram_wdata.sum_re = ram_rdata.sum_re + fva_pkg::t_sum'(r_vis_re);
                        ram_wdata.sum_im = ram_rdata.sum_im + fva_pkg::t_sum'(r_vis_im);
                        ram_wdata.cnt    = ram_rdata.cnt + fva_pkg::t_cnt'(1);
                    end
                end else begin
                    // Read and clear: the entry is zeroed now, the divider
                    // works from the sums it has latched.
                    ram_we = 1'b1;
                    if (ram_rdata.cnt == '0) begin
                        n_strobe = 1'b1;
                        n_status = fva_pkg::STS_READ_EMPTY;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            fva_pkg::FS_DIV: begin
                if (div_done) begin
                    n_strobe = 1'b1;
                    n_status = fva_pkg::STS_READ_OK;
                    n_avg_re = div_re;
                    n_avg_im = div_im;
                    n_count  = r_cnt_hold;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fva_pkg::FS_CLEAR;
            r_clr_addr   <= '0;
            r_skip       <= 16'(fva_pkg::SKIP_RESET);
            r_first_seen <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (r_state == fva_pkg::FS_CLEAR) begin
                r_clr_addr <= r_clr_addr + fva_pkg::t_addr'(1);
            end
            if (i_cfg_we) begin
                r_skip <= i_cfg_wdata;
            end
            if (r_state == fva_pkg::FS_LOOK && first_now) begin
                r_first_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode  <= i_opcode;
            r_ts      <= i_timestamp;
            r_ant_a   <= i_antenna_a;
            r_ant_b   <= i_antenna_b;
            r_polp    <= i_pol_product;
            r_channel <= i_channel;
            r_flagged <= i_flagged;
            r_vis_re  <= i_vis_re;
            r_vis_im  <= i_vis_im;
            r_rbl     <= i_read_baseline;
            r_rpol    <= i_read_pol;
        end
        if (r_state == fva_pkg::FS_LOOK) begin
            r_pre_ok     <= pre_ok;
            r_pre_status <= pre_status;
            r_addr       <= look_addr;
            if (first_now) begin
                r_first_time <= r_ts;
            end
        end
        if (div_start) begin
            r_cnt_hold <= ram_rdata.cnt;
        end
        r_status <= n_status;
        r_avg_re <= n_avg_re;
        r_avg_im <= n_avg_im;
        r_count  <= n_count;
    end

    fva_ram #(
        .WIDTH (fva_pkg::ENTRY_W),
        .DEPTH (fva_pkg::ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (look_addr),
        .o_rdata (ram_rdata)
    );

    fva_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num_re (ram_rdata.sum_re),
        .i_num_im (ram_rdata.sum_im),
        .i_den    (ram_rdata.cnt),
        .o_done   (div_done),
        .o_quo_re (div_re),
        .o_quo_im (div_im)
    );

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_avg_re       = r_avg_re;
    assign o_avg_im       = r_avg_im;
    assign o_sample_count = r_count;

`ifndef SYNTHESIS
    // A result is only shown once the item's work has fully finished.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_state == fva_pkg::FS_IDLE)
        else $error("result strobe while the block is still working");

    // An accepted beat always goes to the memory lookup next.
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == fva_pkg::FS_LOOK)
        else $error("accepted beat did not start a lookup");

    // The lookup cycle must never write the memory.
    a_no_write_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fva_pkg::FS_LOOK |-> !ram_we)
        else $error("memory written during lookup");

    // A successful read carries a non-zero count.
    a_read_ok_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == fva_pkg::STS_READ_OK) |-> o_sample_count != '0)
        else $error("read ok with zero count");

    // Every other result has its data fields zeroed.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != fva_pkg::STS_READ_OK)
        |-> (o_avg_re == '0 && o_avg_im == '0 && o_sample_count == '0))
        else $error("non-read result with data fields set");
`endif

endmodule
